@@ sv/mmst_pkg.sv @@
// Package for the multi-mode string tokenizer: sizes, mode and register codes,
// result record and small helpers. No dependencies.
`default_nettype none

package mmst_pkg;

    localparam int MaxSepLen   = 8;
    localparam int PosWidth    = 16;
    localparam int CfgIdxWidth = 8;
    localparam int CfgDataWidth = 64;
    localparam int SepLenWidth = $clog2(MaxSepLen + 1);

    typedef logic [PosWidth-1:0] pos_t;
    localparam pos_t PosMax = '1;

    typedef enum logic [1:0] {
        MODE_WHITESPACE = 2'd0,
        MODE_SINGLE     = 2'd1,
        MODE_CHARSET    = 2'd2,
        MODE_STRING     = 2'd3
    } split_mode_t;

    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SPLIT_MODE = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_SEP_BYTES  = cfg_idx_t'(1);
    localparam cfg_idx_t CFG_SEP_LEN    = cfg_idx_t'(2);
    localparam cfg_idx_t CFG_MAX_TOKENS = cfg_idx_t'(3);

    typedef struct packed {
        logic        token_valid;
        logic [15:0] token_index;
        pos_t        token_start;
        pos_t        token_len;
        logic        string_done;
        logic [15:0] token_total;
        logic        offset_overflow;
    } result_t;

    function automatic pos_t sat_inc(input pos_t v);
        return (v == PosMax) ? PosMax : pos_t'(v + pos_t'(1));
    endfunction

    function automatic logic [7:0] sep_at(input logic [8*MaxSepLen-1:0] b,
                                          input logic [2:0] k);
        return b[{k, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

@@ sv/mmst_ifs.sv @@
// Channel interfaces of the tokenizer: byte input, token output, register write.
// Depends on mmst_pkg.
`default_nettype none

interface mmst_in_if;
    import mmst_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_string;
    modport source (output valid, char_byte, end_of_string, input ready);
    modport sink   (input valid, char_byte, end_of_string, output ready);
endinterface

interface mmst_out_if;
    import mmst_pkg::*;
    logic        valid;
    logic        ready;
    logic        token_valid;
    logic [15:0] token_index;
    pos_t        token_start;
    pos_t        token_len;
    logic        string_done;
    logic [15:0] token_total;
    logic        offset_overflow;
    modport source (output valid, token_valid, token_index, token_start, token_len,
                    string_done, token_total, offset_overflow, input ready);
    modport sink   (input valid, token_valid, token_index, token_start, token_len,
                    string_done, token_total, offset_overflow, output ready);
endinterface

interface mmst_cfg_if;
    import mmst_pkg::*;
    logic                    valid;
    logic                    ready;
    cfg_idx_t                wr_index;
    logic [CfgDataWidth-1:0] wr_data;
    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

`default_nettype wire

@@ sv/multi_mode_string_tokenizer_core.sv @@
// Top level of the multi-mode string tokenizer: input register, scan logic, result register.
// Depends on mmst_pkg and the interfaces in mmst_ifs.sv.
//
//   channel    dir   payload                                        accepted when
//   char_in    in    char_byte, end_of_string                       valid && ready
//   token_out  out   token_valid/index/start/len, string_done,      valid && ready
//                    token_total, offset_overflow
//   cfg        in    wr_index, wr_data                              valid && ready (always ready)
//
// One request per cycle sustained while the result register is not stalled; a result passes
// through the input register, then the single-pass scan into the result register. A stalled
// result register holds the input register; the input takes a new request in the cycle its
// register drains. Requests that end neither a reported token nor a string leave no result.
// Reset clears control and state registers at once, not the result data; no clearing pass.
`default_nettype none

module multi_mode_string_tokenizer_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mmst_in_if.sink       char_in,
    mmst_out_if.source    token_out,
    mmst_cfg_if.sink      cfg
);
    import mmst_pkg::*;

    split_mode_t              split_mode_reg;
    logic [8*MaxSepLen-1:0]   sep_bytes_reg;
    logic [3:0]               sep_len_reg;
    logic [15:0]              max_tokens_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    pos_t        byte_pos_reg,  byte_pos_next;
    pos_t        seg_start_reg, seg_start_next;
    pos_t        seg_len_reg,   seg_len_next;
    logic [7:0]  recent_reg  [MaxSepLen];
    logic [7:0]  recent_next [MaxSepLen];
    logic [15:0] tokens_reg,    tokens_next;
    logic        ovf_reg,       ovf_next;

    logic    out_valid_reg;
    result_t result_reg, result_next;

    logic                   process;
    logic                   have_result;
    logic [SepLenWidth-1:0] eff_len;
    logic                   match_by_len [MaxSepLen];
    logic                   in_set;
    logic                   is_ws;
    logic                   str_match;
    logic                   have_token;
    logic                   report;
    pos_t                   tok_start;
    pos_t                   tok_len;
    pos_t                   start_eff;
    pos_t                   len_inc;

    assign process       = in_valid_reg && (!out_valid_reg || token_out.ready);
    assign char_in.ready = !in_valid_reg || process;
    assign cfg.ready     = 1'b1;

    always_comb
    begin
        if (sep_len_reg == 4'd0)
            eff_len = SepLenWidth'(1);
        else if (32'(sep_len_reg) > MaxSepLen)
            eff_len = SepLenWidth'(MaxSepLen);
        else
            eff_len = SepLenWidth'(sep_len_reg);
    end

    // shifted window, newest byte first
    always_comb
    begin
        recent_next[0] = in_byte_reg;
        for (int j = 1; j < MaxSepLen; j++)
            recent_next[j] = recent_reg[j-1];
    end

    always_comb
    begin
        in_set = 1'b0;
        for (int k = 0; k < MaxSepLen; k++)
            if ((k < 32'(eff_len)) && (sep_at(sep_bytes_reg, 3'(k)) == in_byte_reg))
                in_set = 1'b1;
    end

    // one match term per possible separator length
    always_comb
    begin
        for (int l = 1; l <= MaxSepLen; l++)
        begin
            match_by_len[l-1] = 1'b1;
            for (int j = 0; j < MaxSepLen; j++)
                if ((j < l) && (recent_next[j] != sep_at(sep_bytes_reg, 3'(l - 1 - j))))
                    match_by_len[l-1] = 1'b0;
        end
    end

    assign str_match = match_by_len[3'(eff_len - SepLenWidth'(1))];
    assign is_ws     = ((in_byte_reg >= 8'd9) && (in_byte_reg <= 8'd13)) ||
                       (in_byte_reg == 8'd32);
    assign start_eff = (seg_len_reg == '0) ? byte_pos_reg : seg_start_reg;
    assign len_inc   = sat_inc(seg_len_reg);

    always_comb
    begin
        byte_pos_next  = byte_pos_reg;
        seg_start_next = seg_start_reg;
        seg_len_next   = seg_len_reg;
        ovf_next       = ovf_reg;
        have_token     = 1'b0;
        tok_start      = seg_start_reg;
        tok_len        = seg_len_reg;

        if (in_eos_reg)
        begin
            have_token = (seg_len_reg != '0);
        end
        else
        begin
            if (byte_pos_reg == PosMax)
                ovf_next = 1'b1;
            byte_pos_next = sat_inc(byte_pos_reg);
            unique case (split_mode_reg)
                MODE_WHITESPACE, MODE_CHARSET:
                begin
                    if ((split_mode_reg == MODE_WHITESPACE) ? is_ws : in_set)
                    begin
                        have_token   = (seg_len_reg != '0);
                        seg_len_next = '0;
                    end
                    else
                    begin
                        seg_start_next = start_eff;
                        seg_len_next   = len_inc;
                    end
                end
                MODE_SINGLE:
                begin
                    seg_start_next = start_eff;
                    tok_start      = start_eff;
                    if (in_byte_reg == sep_at(sep_bytes_reg, 3'd0))
                    begin
                        have_token   = 1'b1;
                        seg_len_next = '0;
                    end
                    else
                        seg_len_next = len_inc;
                end
                MODE_STRING:
                begin
                    seg_start_next = start_eff;
                    tok_start      = start_eff;
                    tok_len        = len_inc - pos_t'(eff_len);
                    if ((len_inc >= pos_t'(eff_len)) && str_match)
                    begin
                        have_token   = 1'b1;
                        seg_len_next = '0;
                    end
                    else
                        seg_len_next = len_inc;
                end
                default:
                begin
                    seg_len_next = seg_len_reg;
                end
            endcase
        end

        report      = have_token && (tokens_reg < max_tokens_reg);
        have_result = report || in_eos_reg;
        tokens_next = tokens_reg + 16'(report);

        result_next.token_valid     = report;
        result_next.token_index     = report ? tokens_reg : 16'd0;
        result_next.token_start     = report ? tok_start : '0;
        result_next.token_len       = report ? tok_len : '0;
        result_next.string_done     = in_eos_reg;
        result_next.token_total     = tokens_next;
        result_next.offset_overflow = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_mode_reg <= MODE_WHITESPACE;
            sep_bytes_reg  <= (8*MaxSepLen)'(44);
            sep_len_reg    <= 4'd1;
            max_tokens_reg <= 16'hFFFF;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.wr_index)
                CFG_SPLIT_MODE: split_mode_reg <= split_mode_t'(cfg.wr_data[1:0]);
                CFG_SEP_BYTES:  sep_bytes_reg  <= cfg.wr_data[8*MaxSepLen-1:0];
                CFG_SEP_LEN:    sep_len_reg    <= cfg.wr_data[3:0];
                CFG_MAX_TOKENS: max_tokens_reg <= cfg.wr_data[15:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= 8'd0;
            in_eos_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            byte_pos_reg  <= '0;
            seg_start_reg <= '0;
            seg_len_reg   <= '0;
            tokens_reg    <= 16'd0;
            ovf_reg       <= 1'b0;
            for (int j = 0; j < MaxSepLen; j++)
                recent_reg[j] <= 8'd0;
        end
        else
        begin
            if (char_in.valid && char_in.ready)
            begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= char_in.char_byte;
                in_eos_reg   <= char_in.end_of_string;
            end
            else if (process)
                in_valid_reg <= 1'b0;

            if (process)
                out_valid_reg <= have_result;
            else if (token_out.ready)
                out_valid_reg <= 1'b0;

            if (process)
            begin
                if (in_eos_reg)
                begin
                    byte_pos_reg  <= '0;
                    seg_start_reg <= '0;
                    seg_len_reg   <= '0;
                    tokens_reg    <= 16'd0;
                    ovf_reg       <= 1'b0;
                    for (int j = 0; j < MaxSepLen; j++)
                        recent_reg[j] <= 8'd0;
                end
                else
                begin
                    byte_pos_reg  <= byte_pos_next;
                    seg_start_reg <= seg_start_next;
                    seg_len_reg   <= seg_len_next;
                    tokens_reg    <= tokens_next;
                    ovf_reg       <= ovf_next;
                    for (int j = 0; j < MaxSepLen; j++)
                        recent_reg[j] <= recent_next[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && have_result)
            result_reg <= result_next;
    end

    assign token_out.valid           = out_valid_reg;
    assign token_out.token_valid     = result_reg.token_valid;
    assign token_out.token_index     = result_reg.token_index;
    assign token_out.token_start     = result_reg.token_start;
    assign token_out.token_len       = result_reg.token_len;
    assign token_out.string_done     = result_reg.string_done;
    assign token_out.token_total     = result_reg.token_total;
    assign token_out.offset_overflow = result_reg.offset_overflow;

endmodule

`default_nettype wire

@@ sv/mmst_checker.sv @@
// Port-level checks on the tokenizer result channel, bound to the top level.
// Depends on mmst_pkg and mmst_out_if.
`default_nettype none

module mmst_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mmst_out_if.source  token_out
);
    import mmst_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_out.valid && !token_out.ready |=> token_out.valid &&
        $stable(token_out.token_total) && $stable(token_out.token_start) &&
        $stable(token_out.string_done))
        else $error("result changed while stalled");

    // empty result carries zero token fields
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        token_out.valid && !token_out.token_valid |->
        token_out.token_index == 16'd0 && token_out.token_start == '0 &&
        token_out.token_len == '0)
        else $error("token fields set without a token");

    a_total_count: assert property (@(posedge clk) disable iff (!rst_n)
        token_out.valid && token_out.token_valid |->
        token_out.token_total == 16'(token_out.token_index + 16'd1))
        else $error("token total does not follow token index");

    // the request after an end of string starts from a clean count
    a_fresh_string: assert property (@(posedge clk) disable iff (!rst_n)
        token_out.valid && token_out.ready && token_out.string_done ##1 token_out.valid |->
        token_out.token_total == 16'(token_out.token_valid) && !token_out.offset_overflow)
        else $error("string state not cleared after end of string");

endmodule

bind multi_mode_string_tokenizer_core mmst_checker u_mmst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .token_out (token_out)
);

`default_nettype wire

@@ tb/sv/multi_mode_string_tokenizer_core_tb.sv @@
// Testbench for multi_mode_string_tokenizer_core: streams strings through all four split modes
// and checks every token result against a built-in predictor of the tokenizer.
// Depends on mmst_pkg and the channel interfaces in mmst_ifs.sv.
module multi_mode_string_tokenizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmst_pkg::*;

    localparam int StallLimit = 2000;
    localparam int HoldCycles = 200;

    logic clk = 1'b0;
    logic rst_n;

    mmst_in_if  char_if();
    mmst_out_if tok_if();
    mmst_cfg_if cfg_if();

    multi_mode_string_tokenizer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_if.sink),
        .token_out (tok_if.source),
        .cfg       (cfg_if.sink)
    );

    always #10 clk = ~clk;

    // register shadow
    split_mode_t  cur_mode;
    logic [63:0]  cur_sep;
    logic [3:0]   cur_sep_len;
    logic [15:0]  cur_max_tokens;

    // tokenizer state
    pos_t         next_offset;
    pos_t         open_start;
    pos_t         open_len;
    logic [7:0]   last_bytes [8];
    logic [15:0]  tokens_out;
    logic         overflow_flag;

    result_t      pending_tokens [$];

    bit           idle_en = 1'b1;
    int           hold_cycles = 0;
    int           mismatch_count = 0;
    int           items_sent = 0;
    int           strings_sent = 0;
    int           results_checked = 0;
    int           tokens_checked = 0;
    int           settings_used = 0;
    int           stall_count = 0;

    function automatic pos_t pos_inc(input pos_t v);
        return (v == PosMax) ? v : v + 1'b1;
    endfunction

    function automatic int sep_width();
        int l;
        l = int'(cur_sep_len);
        if (l == 0) l = 1;
        if (l > MaxSepLen) l = MaxSepLen;
        return l;
    endfunction

    function automatic bit in_sep_set(input logic [7:0] c);
        int l;
        l = sep_width();
        for (int k = 0; k < l; k++)
            if (cur_sep[8*k +: 8] == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit sep_string_seen(input int l);
        for (int j = 0; j < l; j++)
            if (last_bytes[j] != cur_sep[8*(l-1-j) +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_string();
        next_offset   = '0;
        open_start    = '0;
        open_len      = '0;
        tokens_out    = '0;
        overflow_flag = 1'b0;
        for (int j = 0; j < 8; j++) last_bytes[j] = 8'h00;
    endfunction

    function automatic bit report_token(input bit have, input pos_t start, input pos_t len,
                                        input bit done, output result_t r);
        bit rep;
        rep = have && (tokens_out < cur_max_tokens);
        r = '0;
        if (!rep && !done) return 1'b0;
        r.token_valid = rep;
        if (rep) begin
            r.token_index = tokens_out;
            r.token_start = start;
            r.token_len   = len;
            tokens_out    = tokens_out + 1'b1;
        end
        r.string_done     = done;
        r.token_total     = tokens_out;
        r.offset_overflow = overflow_flag;
        return 1'b1;
    endfunction

    function automatic bit tokenize_step(input logic [7:0] c, input bit eos, output result_t r);
        pos_t off;
        bit   hit;
        bit   is_sep;
        int   l;
        r = '0;
        hit = 1'b0;
        if (eos) begin
            hit = report_token(open_len != 0, open_start, open_len, 1'b1, r);
            clear_string();
            return hit;
        end
        off = next_offset;
        if (off == PosMax) overflow_flag = 1'b1;
        next_offset = pos_inc(off);
        for (int j = 7; j > 0; j--) last_bytes[j] = last_bytes[j-1];
        last_bytes[0] = c;
        case (cur_mode)
            MODE_WHITESPACE, MODE_CHARSET:
            begin
                is_sep = (cur_mode == MODE_WHITESPACE) ? ((c >= 8'd9 && c <= 8'd13) || c == 8'd32)
                                                       : in_sep_set(c);
                if (is_sep) begin
                    if (open_len != 0) begin
                        hit = report_token(1'b1, open_start, open_len, 1'b0, r);
                        open_len = '0;
                    end
                end else begin
                    if (open_len == 0) open_start = off;
                    open_len = pos_inc(open_len);
                end
            end
            MODE_SINGLE:
            begin
                if (open_len == 0) open_start = off;
                if (c == cur_sep[7:0]) begin
                    hit = report_token(1'b1, open_start, open_len, 1'b0, r);
                    open_len = '0;
                end else begin
                    open_len = pos_inc(open_len);
                end
            end
            default:
            begin
                l = sep_width();
                if (open_len == 0) open_start = off;
                open_len = pos_inc(open_len);
                if (open_len >= l && sep_string_seen(l)) begin
                    hit = report_token(1'b1, open_start, open_len - pos_t'(l), 1'b0, r);
                    open_len = '0;
                end
            end
        endcase
        return hit;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'($urandom_range(0, 255));
        if (r < 40) begin
            if (cur_mode == MODE_WHITESPACE) begin
                k = $urandom_range(0, 5);
                return (k == 5) ? 8'd32 : 8'(9 + k);
            end
            k = $urandom_range(0, sep_width() - 1);
            return cur_sep[8*k +: 8];
        end
        return 8'(97 + $urandom_range(0, 3));
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR: %s", msg);
    endtask

    task automatic send_char(input logic [7:0] b, input bit eos);
        result_t r;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        char_if.valid         <= 1'b1;
        char_if.char_byte     <= b;
        char_if.end_of_string <= eos;
        @(posedge clk);
        while (!char_if.ready) @(posedge clk);
        items_sent++;
        if (eos) strings_sent++;
        if (tokenize_step(b, eos, r)) pending_tokens.push_back(r);
    endtask

    task automatic send_text(input string s, input bit finish);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
        if (finish) send_char(8'($urandom), 1'b1);
    endtask

    task automatic wait_idle();
        char_if.valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
        cfg_if.valid    <= 1'b1;
        cfg_if.wr_index <= idx;
        cfg_if.wr_data  <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (idx)
            CFG_SPLIT_MODE: cur_mode       = split_mode_t'(val[1:0]);
            CFG_SEP_BYTES:  cur_sep        = val;
            CFG_SEP_LEN:    cur_sep_len    = val[3:0];
            CFG_MAX_TOKENS: cur_max_tokens = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input split_mode_t m, input logic [63:0] sep,
                              input logic [3:0] len, input logic [15:0] max_tok);
        wait_idle();
        write_reg(CFG_SPLIT_MODE, 64'(m));
        write_reg(CFG_SEP_BYTES, sep);
        write_reg(CFG_SEP_LEN, 64'(len));
        write_reg(CFG_MAX_TOKENS, 64'(max_tok));
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_string(input int len, input bit finish);
        int i;
        int l;
        i = 0;
        while (i < len) begin
            l = sep_width();
            if (cur_mode == MODE_STRING && $urandom_range(0, 3) == 0) begin
                for (int k = 0; k < l; k++) send_char(cur_sep[8*k +: 8], 1'b0);
                i += l;
            end else begin
                send_char(pick_byte(), 1'b0);
                i++;
            end
        end
        if (finish) send_char(8'($urandom), 1'b1);
    endtask

    task automatic test_basic_modes();
        // whitespace mode from reset values, class boundaries 8/14 and byte extremes
        send_char(8'd32, 1'b0);
        send_char(8'd97, 1'b0);
        send_char(8'd255, 1'b0);
        send_char(8'd9, 1'b0);
        send_char(8'd0, 1'b0);
        send_char(8'd13, 1'b0);
        send_char(8'd1, 1'b0);
        send_text("\n\v\f\010\016", 1'b1);
        send_text("", 1'b1);
        set_config(MODE_SINGLE, 64'h2C, 4'd1, 16'hFFFF);
        send_text(",a,,b,", 1'b1);
        set_config(MODE_CHARSET, 64'h2C3B00, 4'd3, 16'hFFFF);
        send_char(8'h78, 1'b0);
        send_char(8'h00, 1'b0);
        send_text("y;,,z", 1'b1);
        set_config(MODE_STRING, 64'h6261, 4'd2, 16'hFFFF);
        send_text("aabxababa", 1'b1);
    endtask

    task automatic test_limits_and_sep_len();
        set_config(MODE_WHITESPACE, 64'h2C, 4'd1, 16'd0);
        send_text(" a b ", 1'b1);
        set_config(MODE_WHITESPACE, 64'h2C, 4'd1, 16'd2);
        send_text("a b c d", 1'b1);
        set_config(MODE_STRING, 64'h3B, 4'd0, 16'hFFFF);
        send_text("a;b;", 1'b1);
        set_config(MODE_STRING, 64'h3837363534333231, 4'd15, 16'hFFFF);
        send_text("x12345678y1234567", 1'b1);
    endtask

    task automatic test_mode_switch();
        set_config(MODE_WHITESPACE, 64'h2C, 4'd1, 16'hFFFF);
        send_text("ab c", 1'b0);
        set_config(MODE_SINGLE, 64'h2C, 4'd1, 16'hFFFF);
        send_text(",d,e", 1'b0);
        set_config(MODE_STRING, 64'h2D2D, 4'd2, 16'hFFFF);
        send_text("f--g", 1'b1);
    endtask

    task automatic test_backpressure();
        set_config(MODE_SINGLE, 64'h2C, 4'd1, 16'hFFFF);
        hold_cycles = HoldCycles;
        repeat (40) send_char(($urandom_range(0, 4) == 0) ? 8'h78 : 8'h2C, 1'b0);
        send_char(8'h00, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic [7:0]  pool [6] = '{8'h2C, 8'h3B, 8'h20, 8'h61, 8'h62, 8'h00};
        logic [63:0] sep;
        logic [3:0]  slen;
        logic [15:0] max_tok;
        split_mode_t m;
        int          first;
        int          r;
        for (int phase = 0; phase < 18; phase++) begin
            if (phase >= 15) idle_en = 1'b0;
            m = (phase < 8) ? split_mode_t'(phase % 4) : split_mode_t'($urandom_range(0, 3));
            for (int k = 0; k < 8; k++)
                sep[8*k +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                     : pool[$urandom_range(0, 5)];
            r = $urandom_range(0, 9);
            slen = (r == 0) ? 4'd0 : (r == 1) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(1, 8));
            r = $urandom_range(0, 9);
            max_tok = (r == 0) ? 16'd0 : (r < 3) ? 16'($urandom_range(1, 4))
                                       : (r == 3) ? 16'($urandom) : 16'hFFFF;
            if (phase == 1) max_tok = 16'd0;
            if (phase == 2) begin
                sep  = '1;
                slen = 4'd8;
            end
            set_config(m, sep, slen, max_tok);
            first = items_sent;
            while (items_sent - first < 90)
                send_random_string(($urandom_range(0, 19) == 0) ? $urandom_range(40, 80)
                                                                : $urandom_range(0, 16),
                                   $urandom_range(0, 9) != 0);
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        tok_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                tok_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                tok_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                tok_if.ready <= 1'b0;
            end else begin
                tok_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : token_checker
        result_t got;
        result_t want;
        if (rst_n && tok_if.valid && tok_if.ready) begin
            got.token_valid     = tok_if.token_valid;
            got.token_index     = tok_if.token_index;
            got.token_start     = tok_if.token_start;
            got.token_len       = tok_if.token_len;
            got.string_done     = tok_if.string_done;
            got.token_total     = tok_if.token_total;
            got.offset_overflow = tok_if.offset_overflow;
            results_checked++;
            if (got.token_valid === 1'b1) tokens_checked++;
            if (pending_tokens.size() == 0) begin
                note_mismatch($sformatf("result with nothing expected: valid=%0b idx=%0d",
                                        got.token_valid, got.token_index));
            end else begin
                want = pending_tokens.pop_front();
                if (got !== want)
                    note_mismatch($sformatf({"result %0d: expected tv=%0b idx=%0d start=%0d ",
                        "len=%0d done=%0b total=%0d ovf=%0b, got tv=%0b idx=%0d start=%0d ",
                        "len=%0d done=%0b total=%0d ovf=%0b"}, results_checked,
                        want.token_valid, want.token_index, want.token_start, want.token_len,
                        want.string_done, want.token_total, want.offset_overflow,
                        got.token_valid, got.token_index, got.token_start, got.token_len,
                        got.string_done, got.token_total, got.offset_overflow));
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if ((char_if.valid && char_if.ready) || (tok_if.valid && tok_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count == StallLimit) begin
            $display("ERROR: no request moved for %0d cycles", StallLimit);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        rst_n                 = 1'b0;
        char_if.valid         = 1'b0;
        char_if.char_byte     = 8'h00;
        char_if.end_of_string = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.wr_index       = CFG_SPLIT_MODE;
        cfg_if.wr_data        = '0;
        cur_mode              = MODE_WHITESPACE;
        cur_sep               = 64'h2C;
        cur_sep_len           = 4'd1;
        cur_max_tokens        = 16'hFFFF;
        clear_string();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_modes();
        test_limits_and_sep_len();
        test_mode_switch();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (8) @(posedge clk);
        if (pending_tokens.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_tokens.size()));
        $display("Sent %0d bytes and ends in %0d strings over %0d register settings, all modes.",
                 items_sent, strings_sent, settings_used);
        $display("Checked %0d results (%0d tokens), incl. token limits, mode switches, stalls.",
                 results_checked, tokens_checked);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
